// ----- rtl/core/tlvd_pkg.sv -----
// Shared types, codes and the CRC-32 byte update for the TLV record deframer.
// Used by tlvd_parser, tlvd_out_reg and the top level; no dependencies.
package tlvd_pkg;

    localparam logic [1:0] ACT_START  = 2'd0;
    localparam logic [1:0] ACT_DATA   = 2'd1;
    localparam logic [1:0] ACT_FINISH = 2'd2;

    localparam logic [1:0] KIND_HEADER = 2'd0;
    localparam logic [1:0] KIND_VALUE  = 2'd1;
    localparam logic [1:0] KIND_STATUS = 2'd2;
    localparam logic [1:0] KIND_FORMAT = 2'd3;

    localparam logic [1:0] ST_OK     = 2'd0;
    localparam logic [1:0] ST_FORMAT = 2'd1;
    localparam logic [1:0] ST_CRC    = 2'd2;

    localparam logic [31:0] CRC_POLY      = 32'hEDB8_8320;
    localparam logic [31:0] HEADER_BYTES  = 32'd4;

    typedef struct packed {
        logic        valid;
        logic [1:0]  result_kind;
        logic [15:0] record_tag;
        logic [15:0] record_length;
        logic [7:0]  value_byte;
        logic [15:0] value_offset;
        logic        last_of_record;
        logic [1:0]  status_code;
    } tlvd_result_t;

    function automatic logic [31:0] crc_byte(input logic [31:0] crc, input logic [7:0] b);
        logic [31:0] c;
        c = ~crc ^ {24'd0, b};
        for (int i = 0; i < 8; i++)
        begin
            c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
        end
        return ~c;
    endfunction

endpackage

// ----- rtl/core/tlvd_parser.sv -----
// Parser state and per-word next-state logic: header assembly, value tracking, CRC.
// Depends on tlvd_pkg; produces one tlvd_result_t per accepted word.
module tlvd_parser
    import tlvd_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         fire,
    input  logic [1:0]   action,
    input  logic [7:0]   data_byte,
    input  logic [31:0]  payload_length,
    input  logic [31:0]  expected_crc,
    output tlvd_result_t result
);

    logic [31:0] crc_reg, crc_next;
    logic [31:0] consumed_reg, consumed_next;
    logic [31:0] total_reg, total_next;
    logic [31:0] expect_reg, expect_next;
    logic [1:0]  hbs_reg, hbs_next;
    logic [15:0] tag_reg, tag_next;
    logic [15:0] len_reg, len_next;
    logic [15:0] rbr_reg, rbr_next;
    logic        err_reg, err_next;
    logic        inval_reg, inval_next;

    logic [31:0] remaining;
    logic [31:0] crc_upd;
    logic [15:0] off_inc;

    assign remaining = total_reg - consumed_reg;
    assign crc_upd   = crc_byte(crc_reg, data_byte);
    assign off_inc   = rbr_reg + 16'd1;

    always_comb
    begin
        crc_next      = crc_reg;
        consumed_next = consumed_reg;
        total_next    = total_reg;
        expect_next   = expect_reg;
        hbs_next      = hbs_reg;
        tag_next      = tag_reg;
        len_next      = len_reg;
        rbr_next      = rbr_reg;
        err_next      = err_reg;
        inval_next    = inval_reg;
        result        = '0;
        case (action)
            ACT_START:
            begin
                crc_next      = '0;
                consumed_next = '0;
                total_next    = payload_length;
                expect_next   = expected_crc;
                hbs_next      = '0;
                tag_next      = '0;
                len_next      = '0;
                rbr_next      = '0;
                err_next      = 1'b0;
                inval_next    = 1'b0;
            end
            ACT_FINISH:
            begin
                result.valid       = 1'b1;
                result.result_kind = KIND_STATUS;
                if (err_reg || consumed_reg != total_reg)
                    result.status_code = ST_FORMAT;
                else if (crc_reg != expect_reg)
                    result.status_code = ST_CRC;
                else
                    result.status_code = ST_OK;
            end
            ACT_DATA:
            begin
                if (!err_reg && consumed_reg < total_reg)
                begin
                    if (inval_reg)
                    begin
                        crc_next      = crc_upd;
                        consumed_next = consumed_reg + 32'd1;
                        rbr_next      = off_inc;
                        if (off_inc == len_reg)
                        begin
                            inval_next = 1'b0;
                            hbs_next   = '0;
                        end
                        result.valid          = 1'b1;
                        result.result_kind    = KIND_VALUE;
                        result.record_tag     = tag_reg;
                        result.record_length  = len_reg;
                        result.value_byte     = data_byte;
                        result.value_offset   = rbr_reg;
                        result.last_of_record = (off_inc == len_reg);
                    end
                    else if (hbs_reg == 2'd0 && remaining < HEADER_BYTES)
                    begin
                        err_next           = 1'b1;
                        result.valid       = 1'b1;
                        result.result_kind = KIND_FORMAT;
                        result.status_code = ST_FORMAT;
                    end
                    else
                    begin
                        crc_next      = crc_upd;
                        consumed_next = consumed_reg + 32'd1;
                        case (hbs_reg)
                            2'd0:    tag_next = {8'd0, data_byte};
                            2'd1:    tag_next = {data_byte, tag_reg[7:0]};
                            2'd2:    len_next = {8'd0, data_byte};
                            default: len_next = {data_byte, len_reg[7:0]};
                        endcase
                        if (hbs_reg != 2'd3)
                        begin
                            hbs_next = hbs_reg + 2'd1;
                        end
                        else
                        begin
                            hbs_next             = '0;
                            result.valid         = 1'b1;
                            result.record_tag    = tag_reg;
                            result.record_length = len_next;
                            if ({16'd0, len_next} > remaining - 32'd1)
                            begin
                                err_next           = 1'b1;
                                result.result_kind = KIND_FORMAT;
                                result.status_code = ST_FORMAT;
                            end
                            else
                            begin
                                rbr_next           = '0;
                                inval_next         = (len_next != 16'd0);
                                result.result_kind = KIND_HEADER;
                            end
                        end
                    end
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            crc_reg      <= '0;
            consumed_reg <= '0;
            total_reg    <= '0;
            expect_reg   <= '0;
            hbs_reg      <= '0;
            tag_reg      <= '0;
            len_reg      <= '0;
            rbr_reg      <= '0;
            err_reg      <= 1'b0;
            inval_reg    <= 1'b0;
        end
        else if (fire)
        begin
            crc_reg      <= crc_next;
            consumed_reg <= consumed_next;
            total_reg    <= total_next;
            expect_reg   <= expect_next;
            hbs_reg      <= hbs_next;
            tag_reg      <= tag_next;
            len_reg      <= len_next;
            rbr_reg      <= rbr_next;
            err_reg      <= err_next;
            inval_reg    <= inval_next;
        end
    end

    a_consumed_bound: assert property (@(posedge clk) disable iff (!rst_n)
        consumed_reg <= total_reg)
        else $error("consumed count passed payload total");

    a_value_no_header: assert property (@(posedge clk) disable iff (!rst_n)
        inval_reg |-> (hbs_reg == 2'd0 && !err_reg && rbr_reg < len_reg))
        else $error("value phase with inconsistent header state");

    a_error_freezes_crc: assert property (@(posedge clk) disable iff (!rst_n)
        (fire && action == ACT_DATA && err_reg) |=> $stable(crc_reg) && $stable(consumed_reg))
        else $error("data word consumed while error set");

    a_finish_keeps_state: assert property (@(posedge clk) disable iff (!rst_n)
        (fire && action == ACT_FINISH) |=> $stable(crc_reg) && $stable(hbs_reg))
        else $error("finish word changed parser state");

endmodule

// ----- rtl/core/tlvd_out_reg.sv -----
// Result register between the parser and the output channel.
// Depends on tlvd_pkg; holds one result word until it is taken.
module tlvd_out_reg
    import tlvd_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         fire,
    input  tlvd_result_t result,
    input  logic         out_ready,
    output logic         in_ready,
    output logic         out_valid,
    output tlvd_result_t held
);

    logic         valid_reg, valid_next;
    tlvd_result_t data_reg;

    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign held      = data_reg;

    always_comb
    begin
        valid_next = valid_reg;
        if (fire)
            valid_next = result.valid;
        else if (out_ready)
            valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (fire && result.valid)
            data_reg <= result;
    end

endmodule

// ----- rtl/core/tlv_record_deframer_crc32_top.sv -----
// TLV record deframer with CRC-32 check, top level.
// Takes one input word a cycle; each word is handled by combinational parser logic,
// so a new word is accepted in every cycle while the result register is empty or
// being taken. A result is registered and appears in the cycle after its word;
// start words and ignored bytes give none. The throughput of one word per cycle is
// set by the combinational CRC byte update and header/length compare in the parser
// ahead of the result register. Depends on tlvd_pkg, tlvd_parser and tlvd_out_reg.
module tlv_record_deframer_crc32_top
    import tlvd_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [1:0]  action,
    input  logic [7:0]  data_byte,
    input  logic [31:0] payload_length,
    input  logic [31:0] expected_crc,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [1:0]  result_kind,
    output logic [15:0] record_tag,
    output logic [15:0] record_length,
    output logic [7:0]  value_byte,
    output logic [15:0] value_offset,
    output logic        last_of_record,
    output logic [1:0]  status_code
);

    logic         fire;
    tlvd_result_t result;
    tlvd_result_t held;

    assign fire = in_valid && in_ready;

    tlvd_parser u_parser (
        .clk            (clk),
        .rst_n          (rst_n),
        .fire           (fire),
        .action         (action),
        .data_byte      (data_byte),
        .payload_length (payload_length),
        .expected_crc   (expected_crc),
        .result         (result)
    );

    tlvd_out_reg u_out_reg (
        .clk       (clk),
        .rst_n     (rst_n),
        .fire      (fire),
        .result    (result),
        .out_ready (out_ready),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .held      (held)
    );

    assign result_kind    = held.result_kind;
    assign record_tag     = held.record_tag;
    assign record_length  = held.record_length;
    assign value_byte     = held.value_byte;
    assign value_offset   = held.value_offset;
    assign last_of_record = held.last_of_record;
    assign status_code    = held.status_code;

endmodule
